@@ sv/mtrgb_pkg.sv @@
// Shared types, constants and swizzle functions of the Z-order texel swizzler.
`timescale 1ns / 1ps

package mtrgb_pkg;

    // Defaults for the top-level parameters
    localparam int DEF_MAX_TILES_WIDE = 12;
    localparam int DEF_MAX_TILES_HIGH = 6;
    localparam int DEF_ICON_SIZE      = 48;

    // Fixed by the register field widths: 4-bit tile count x 64, 3-bit tile count x 64
    localparam int DIM_W_X  = 10;
    localparam int DIM_W_Y  = 9;
    localparam int TILE_W   = 7;
    localparam int IDX_W    = 19;
    localparam int SUM_W    = 9;
    localparam int PAIR_W   = 4 * SUM_W;

    // Configuration register indexes
    localparam logic [1:0] CFG_ICON_MODE  = 2'd0;
    localparam logic [1:0] CFG_TILES_WIDE = 2'd1;
    localparam logic [1:0] CFG_TILES_HIGH = 2'd2;

    // One accepted pixel, ready for the output stage
    typedef struct packed {
        logic                err;
        logic                last;
        logic                has_mip;
        logic [IDX_W-1:0]    idx;
        logic [IDX_W-1:0]    midx;
        logic [15:0]         color;
        logic [3:0]          alpha;
        logic [SUM_W-1:0]    pr;
        logic [SUM_W-1:0]    pg;
        logic [SUM_W-1:0]    pb;
        logic [SUM_W-1:0]    pa;
    } item_t;

    // One result transaction
    typedef struct packed {
        logic                level;
        logic [IDX_W-1:0]    idx;
        logic [15:0]         color;
        logic [3:0]          alpha;
        logic                err;
        logic                run_end;
        logic                image_end;
    } result_t;

    // 8x8 blocks of 8x8 texels: blocks in row-major order, texels Morton ordered within a block
    function automatic logic [11:0] morton_full(input logic [5:0] x, input logic [5:0] y);
        morton_full = {y[5:3], x[5:3], y[2], x[2], y[1], x[1], y[0], x[0]};
    endfunction

    // Half-size coordinates: 4x4 blocks of 8x8 texels
    function automatic logic [9:0] morton_mip(input logic [5:0] x, input logic [5:0] y);
        morton_mip = {y[5:4], x[5:4], y[3], x[3], y[2], x[2], y[1], x[1]};
    endfunction

endpackage

@@ sv/mtrgb_ram.sv @@
// Generic simple dual-port RAM with registered read.
`timescale 1ns / 1ps

module mtrgb_ram #(
    parameter int WIDTH = 36,
    parameter int DEPTH = 384,
    localparam int AW   = $clog2(DEPTH)
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic             re,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

@@ sv/mtrgb_front.sv @@
// Input side: configuration, raster counters, swizzle addressing and line store access.
`timescale 1ns / 1ps

module mtrgb_front import mtrgb_pkg::*; #(
    parameter int MAX_TILES_WIDE = DEF_MAX_TILES_WIDE,
    parameter int MAX_TILES_HIGH = DEF_MAX_TILES_HIGH,
    parameter int ICON_SIZE      = DEF_ICON_SIZE,
    localparam int COL_W         = $clog2(MAX_TILES_WIDE * 64),
    localparam int ROW_W         = $clog2(MAX_TILES_HIGH * 64),
    localparam int LINE_AW       = COL_W - 1
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cfg_valid,
    input  logic [1:0]         cfg_index,
    input  logic [3:0]         cfg_data,
    input  logic               pix_valid,
    input  logic               pix_ready,
    input  logic [31:0]        pix_data,
    output item_t              item,
    output logic               line_we,
    output logic [LINE_AW-1:0] line_waddr,
    output logic [PAIR_W-1:0]  line_wdata,
    output logic               line_re,
    output logic [LINE_AW-1:0] line_raddr
);

    logic              icon_reg, icon_next;
    logic [3:0]        tw_reg, tw_next;
    logic [2:0]        th_reg, th_next;
    logic [COL_W-1:0]  col_reg, col_next;
    logic [ROW_W-1:0]  row_reg, row_next;
    logic [31:0]       left_reg, left_next;

    logic                restart;
    logic                accept;
    logic                bad;
    logic [DIM_W_X-1:0]  xe, wm1;
    logic [DIM_W_Y-1:0]  ye, hm1;
    logic                x_end, y_end;
    logic [TILE_W-1:0]   tile;
    logic [SUM_W-1:0]    pr, pg, pb, pa;

    assign accept = pix_valid && pix_ready;

    // Register decode; any known index restarts the image
    always_comb
    begin
        icon_next = icon_reg;
        tw_next   = tw_reg;
        th_next   = th_reg;
        restart   = 1'b0;
        if (cfg_valid)
        begin
            unique case (cfg_index)
                CFG_ICON_MODE:
                begin
                    icon_next = cfg_data[0];
                    restart   = 1'b1;
                end
                CFG_TILES_WIDE:
                begin
                    tw_next = cfg_data;
                    restart = 1'b1;
                end
                CFG_TILES_HIGH:
                begin
                    th_next = cfg_data[2:0];
                    restart = 1'b1;
                end
                default:
                begin
                end
            endcase
        end
    end

    assign bad = !icon_reg && (tw_reg == 4'd0 || {1'b0, tw_reg} > 5'(MAX_TILES_WIDE) ||
                               th_reg == 3'd0 || {1'b0, th_reg} > 4'(MAX_TILES_HIGH));

    assign xe  = DIM_W_X'(col_reg);
    assign ye  = DIM_W_Y'(row_reg);
    assign wm1 = icon_reg ? DIM_W_X'(ICON_SIZE - 1) : {tw_reg - 4'd1, 6'h3F};
    assign hm1 = icon_reg ? DIM_W_Y'(ICON_SIZE - 1) : {th_reg - 3'd1, 6'h3F};
    assign x_end = (xe == wm1);
    assign y_end = (ye == hm1);

    // Column-major tile number; zero in icon mode since x, y stay below 64
    assign tile = TILE_W'({4'b0, th_reg} * {3'b0, xe[9:6]}) + TILE_W'(ye[8:6]);

    assign pr = SUM_W'(left_reg[7:0])   + SUM_W'(pix_data[7:0]);
    assign pg = SUM_W'(left_reg[15:8])  + SUM_W'(pix_data[15:8]);
    assign pb = SUM_W'(left_reg[23:16]) + SUM_W'(pix_data[23:16]);
    assign pa = SUM_W'(left_reg[31:24]) + SUM_W'(pix_data[31:24]);

    always_comb
    begin
        item = '0;
        if (bad)
        begin
            item.err = 1'b1;
        end
        else
        begin
            item.last    = x_end && y_end;
            item.has_mip = xe[0] && ye[0];
            item.idx     = {tile, morton_full(xe[5:0], ye[5:0])};
            item.midx    = IDX_W'({tile, morton_mip(xe[5:0], ye[5:0])});
            item.color   = {pix_data[7:3], pix_data[15:10], pix_data[23:19]};
            item.alpha   = pix_data[31:28];
            item.pr      = pr;
            item.pg      = pg;
            item.pb      = pb;
            item.pa      = pa;
        end
    end

    // Even rows store pair sums, odd rows fetch them
    assign line_we    = accept && !bad && xe[0] && !ye[0];
    assign line_waddr = col_reg[COL_W-1:1];
    assign line_wdata = {pa, pb, pg, pr};
    assign line_re    = accept;
    assign line_raddr = col_reg[COL_W-1:1];

    always_comb
    begin
        col_next  = col_reg;
        row_next  = row_reg;
        left_next = left_reg;
        if (restart)
        begin
            col_next  = '0;
            row_next  = '0;
            left_next = '0;
        end
        else if (accept && !bad)
        begin
            if (!xe[0])
            begin
                left_next = pix_data;
            end
            if (x_end)
            begin
                col_next = '0;
                row_next = y_end ? '0 : row_reg + ROW_W'(1);
            end
            else
            begin
                col_next = col_reg + COL_W'(1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            icon_reg <= 1'b0;
            tw_reg   <= 4'd1;
            th_reg   <= 3'd1;
            col_reg  <= '0;
            row_reg  <= '0;
            left_reg <= '0;
        end
        else
        begin
            icon_reg <= icon_next;
            tw_reg   <= tw_next;
            th_reg   <= th_next;
            col_reg  <= col_next;
            row_reg  <= row_next;
            left_reg <= left_next;
        end
    end

endmodule

@@ sv/mtrgb_back.sv @@
// Output side: pixel holding stage, mip averaging and result register.
`timescale 1ns / 1ps

module mtrgb_back import mtrgb_pkg::*; (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    input  item_t             in_item,
    input  logic [PAIR_W-1:0] line_rdata,
    output logic              out_valid,
    input  logic              out_ready,
    output result_t           out_res
);

    logic     s1_valid_reg, s1_valid_next;
    item_t    s1_item_reg, s1_item_next;
    logic     s1_phase_reg, s1_phase_next;
    logic     out_valid_reg, out_valid_next;
    result_t  out_res_reg, out_res_next;

    logic              out_free, load, s1_done;
    logic [SUM_W:0]    sr, sg, sb, sa;
    result_t           full_res, mip_res;

    assign out_free = !out_valid_reg || out_ready;
    assign load     = s1_valid_reg && out_free;
    assign s1_done  = load && (!s1_item_reg.has_mip || s1_phase_reg);
    assign in_ready = !s1_valid_reg || s1_done;

    // Add the stored pair of the row above to this row's pair
    assign sr = (SUM_W + 1)'(line_rdata[8:0])   + (SUM_W + 1)'(s1_item_reg.pr);
    assign sg = (SUM_W + 1)'(line_rdata[17:9])  + (SUM_W + 1)'(s1_item_reg.pg);
    assign sb = (SUM_W + 1)'(line_rdata[26:18]) + (SUM_W + 1)'(s1_item_reg.pb);
    assign sa = (SUM_W + 1)'(line_rdata[35:27]) + (SUM_W + 1)'(s1_item_reg.pa);

    always_comb
    begin
        full_res           = '0;
        full_res.idx       = s1_item_reg.idx;
        full_res.color     = s1_item_reg.color;
        full_res.alpha     = s1_item_reg.alpha;
        full_res.err       = s1_item_reg.err;
        full_res.run_end   = !s1_item_reg.has_mip;
        full_res.image_end = s1_item_reg.last;

        mip_res            = '0;
        mip_res.level      = 1'b1;
        mip_res.idx        = s1_item_reg.midx;
        mip_res.color      = {sr[9:5], sg[9:4], sb[9:5]};
        mip_res.alpha      = sa[9:6];
        mip_res.run_end    = 1'b1;
        mip_res.image_end  = s1_item_reg.last;
    end

    always_comb
    begin
        s1_valid_next  = s1_valid_reg;
        s1_item_next   = s1_item_reg;
        s1_phase_next  = s1_phase_reg;
        out_valid_next = out_valid_reg;
        out_res_next   = out_res_reg;

        if (load)
        begin
            out_valid_next = 1'b1;
            out_res_next   = s1_phase_reg ? mip_res : full_res;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end

        if (in_ready)
        begin
            s1_valid_next = in_valid;
            s1_phase_next = 1'b0;
            if (in_valid)
            begin
                s1_item_next = in_item;
            end
        end
        else if (load)
        begin
            s1_phase_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            s1_phase_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg  <= s1_valid_next;
            s1_phase_reg  <= s1_phase_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        s1_item_reg <= s1_item_next;
        out_res_reg <= out_res_next;
    end

    assign out_valid = out_valid_reg;
    assign out_res   = out_res_reg;

    a_phase_needs_mip: assert property (@(posedge clk) disable iff (!rst_n)
        s1_phase_reg |-> s1_valid_reg && s1_item_reg.has_mip)
        else $error("mip phase without a mip item");

    a_err_no_mip: assert property (@(posedge clk) disable iff (!rst_n)
        s1_valid_reg && s1_item_reg.err |-> !s1_item_reg.has_mip)
        else $error("error item carries a mip texel");

    a_phase_advance: assert property (@(posedge clk) disable iff (!rst_n)
        load && s1_item_reg.has_mip && !s1_phase_reg |=> s1_phase_reg && s1_valid_reg)
        else $error("mip result not scheduled after full texel");

    a_mip_ends_run: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && out_res_reg.level |-> out_res_reg.run_end && !out_res_reg.err)
        else $error("mip result without run end");

endmodule

@@ sv/morton_tile_rgb565_a4_with_mip_core.sv @@
// Top level of the Z-order RGB565/A4 texel swizzler with 2x2 mip.
//
// Channel  | Dir | Handshake              | Content
// ---------+-----+------------------------+---------------------------------------
// s_*      | in  | s_tvalid / s_tready    | one RGBA8888 pixel, raster order
// m_*      | out | m_tvalid / m_tready    | one texel result (full-size or mip)
// cfg_*    | in  | cfg_valid / cfg_ready  | register write: index + data
//
// Flow: a pixel is taken every clock while s_tready is high; its full-size texel passes from
// the holding stage into the result register. A pixel on an odd row and odd column also
// yields a mip texel, so it stays in the holding stage while the single output register
// sends its full-size result and then its mip result on m_*.
// The line store is a registered-read RAM of MAX_TILES_WIDE*32 pair sums; an odd row
// reads the entry its even row wrote, never in the same cycle, so no forwarding exists.
// Reset: counters clear, registers go to icon_mode 0, tiles 1x1; the line store is not
// cleared and needs no pass. Stalls: m_tready low holds the result, then the holding
// stage, then s_tready drops. cfg_ready is always high; write only while idle.
`timescale 1ns / 1ps

module morton_tile_rgb565_a4_with_mip_core import mtrgb_pkg::*; #(
    parameter int MAX_TILES_WIDE = DEF_MAX_TILES_WIDE,
    parameter int MAX_TILES_HIGH = DEF_MAX_TILES_HIGH,
    parameter int ICON_SIZE      = DEF_ICON_SIZE
) (
    input  logic        clk,
    input  logic        rst_n,
    // s_tdata: red [7:0], green [15:8], blue [23:16], opacity [31:24]
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,
    // m_tdata: texel_index [18:0], color565 [34:19], alpha_nibble [38:35], zero [39]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [39:0] m_tdata,
    // m_tuser: level [0], size_error [1], image_end [2]
    output logic [2:0]  m_tuser,
    // m_tlast: run_end, last result of this pixel
    output logic        m_tlast,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [3:0]  cfg_data
);

    localparam int LINE_DEPTH = MAX_TILES_WIDE * 32;
    localparam int LINE_AW    = $clog2(MAX_TILES_WIDE * 64) - 1;

    item_t              item;
    result_t            res;
    logic               line_we, line_re;
    logic [LINE_AW-1:0] line_waddr, line_raddr;
    logic [PAIR_W-1:0]  line_wdata, line_rdata;

    assign cfg_ready = 1'b1;

    // Addressing, counters and line store access on each pixel transaction
    mtrgb_front #(
        .MAX_TILES_WIDE (MAX_TILES_WIDE),
        .MAX_TILES_HIGH (MAX_TILES_HIGH),
        .ICON_SIZE      (ICON_SIZE)
    ) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_valid  (cfg_valid),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .pix_valid  (s_tvalid),
        .pix_ready  (s_tready),
        .pix_data   (s_tdata),
        .item       (item),
        .line_we    (line_we),
        .line_waddr (line_waddr),
        .line_wdata (line_wdata),
        .line_re    (line_re),
        .line_raddr (line_raddr)
    );

    // Pair sums of the even row, one entry per horizontal pixel pair
    mtrgb_ram #(
        .WIDTH (PAIR_W),
        .DEPTH (LINE_DEPTH)
    ) u_line (
        .clk   (clk),
        .we    (line_we),
        .waddr (line_waddr),
        .wdata (line_wdata),
        .re    (line_re),
        .raddr (line_raddr),
        .rdata (line_rdata)
    );

    // Hold the pixel, finish the mip average and sequence up to two results
    mtrgb_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (s_tvalid),
        .in_ready   (s_tready),
        .in_item    (item),
        .line_rdata (line_rdata),
        .out_valid  (m_tvalid),
        .out_ready  (m_tready),
        .out_res    (res)
    );

    assign m_tdata = {1'b0, res.alpha, res.color, res.idx};
    assign m_tuser = {res.image_end, res.err, res.level};
    assign m_tlast = res.run_end;

endmodule
